FILE: sv/generational_handle_pool_core_defines.svh
// assertion macros for the generational handle pool
// used by generational_handle_pool_core; expects clk and rst_n in scope
`ifndef GENERATIONAL_HANDLE_POOL_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_POOL_CORE_DEFINES_SVH

// same-cycle implication
`define GHP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GHP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ghp_pkg.sv
// shared constants, types and helpers for the generational handle pool
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ghp_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_AW   = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_AW + 1;
    localparam int GEN_W     = 8;
    localparam int KIND_W    = 8;
    localparam int HIDX_W    = 16;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SLOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 2'd2;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               clr;
        logic [SLOT_AW-1:0] addr;
        logic               used;
        logic [GEN_W-1:0]   gen;
    } slot_req_t;

    typedef struct packed {
        logic             used;
        logic [GEN_W-1:0] gen;
    } slot_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_max(input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] r;
        r = m;
        if (r < CNT_W'(2))
        begin
            r = CNT_W'(2);
        end
        if (r > CNT_W'(MAX_SLOTS))
        begin
            r = CNT_W'(MAX_SLOTS);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_init(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] r;
        r = v;
        if (r < CNT_W'(2))
        begin
            r = CNT_W'(2);
        end
        if (r > m)
        begin
            r = m;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ghp_channels.sv
// request and response channel interfaces of the generational handle pool
// depends on ghp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ghp_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ghp_pkg::CMD_W-1:0]    command;
    logic [ghp_pkg::KIND_W-1:0]   handle_kind;
    logic [ghp_pkg::HIDX_W-1:0]   handle_index;
    logic [ghp_pkg::GEN_W-1:0]    handle_generation;

    modport source (output valid, command, handle_kind, handle_index, handle_generation,
                    input ready);
    modport sink (input valid, command, handle_kind, handle_index, handle_generation,
                  output ready);
endinterface

interface ghp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [ghp_pkg::KIND_W-1:0]    out_kind;
    logic [ghp_pkg::SLOT_AW-1:0]   out_index;
    logic [ghp_pkg::GEN_W-1:0]     out_generation;

    modport source (output valid, ok, out_kind, out_index, out_generation,
                    input ready);
    modport sink (input valid, ok, out_kind, out_index, out_generation,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/generational_handle_pool_core.sv
// generational handle pool: top level with control sequencer and free-index ring
// depends on ghp_pkg, ghp_channels, ghp_slot_store and the assertion macro header
//
// usage
//   cmd carries one request: command, handle_kind, handle_index, handle_generation
//   rsp carries one answer per request: ok, out_kind, out_index, out_generation
//   cfg_we/cfg_index/cfg_data write pool_kind (0), initial_slots (1), max_slots (2)
//   while the pool is idle; writing initial_slots empties the pool
// timing
//   one request is in work at a time; the answer sits in an output register so
//   the next request is taken while the answer waits for rsp.ready
//   free, resolve and lookup pass through decode, check and done; alloc from the
//   ring through decode, ring, alloc and done; clear and early failures go from
//   decode to done; the next request is taken once done has loaded the answer
//   alloc without freed slots scans slot memory from the first never-used index,
//   reading then checking each slot (single read port, registered read), and
//   commits in alloc; past capacity the pool grows and takes its first new slot
// reset
//   all slots read as free with generation zero at once (per-slot valid bits),
//   capacity 2, pool_kind 0 so alloc fails until a kind is written
//   a stalled receiver holds the answer; the sequencer waits in its final state
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_pool_core_defines.svh"

module generational_handle_pool_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ghp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ghp_pkg::CFG_W-1:0]      cfg_data,
    ghp_cmd_if.sink                             cmd,
    ghp_rsp_if.source                           rsp
);

    localparam int AW = ghp_pkg::SLOT_AW;
    localparam int CW = ghp_pkg::CNT_W;
    localparam int GW = ghp_pkg::GEN_W;
    localparam int KW = ghp_pkg::KIND_W;
    localparam int HW = ghp_pkg::HIDX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_RING    = 3'd2;
    localparam logic [2:0] S_SCAN_RD = 3'd3;
    localparam logic [2:0] S_SCAN_CK = 3'd4;
    localparam logic [2:0] S_ALLOC   = 3'd5;
    localparam logic [2:0] S_CHECK   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]               state_reg, state_next;

    // latched request
    logic [ghp_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [KW-1:0]            hkind_reg, hkind_next;
    logic [HW-1:0]            hidx_reg, hidx_next;
    logic [GW-1:0]            hgen_reg, hgen_next;

    // configuration
    logic [KW-1:0]            pool_kind_reg, pool_kind_next;
    logic [CW-1:0]            max_slots_reg, max_slots_next;

    // pool bookkeeping
    logic [CW-1:0]            cap_reg, cap_next;
    logic [AW-1:0]            ring_head_reg, ring_head_next;
    logic [CW-1:0]            ring_count_reg, ring_count_next;
    logic [CW-1:0]            next_unused_reg, next_unused_next;
    logic [CW-1:0]            scan_idx_reg, scan_idx_next;
    logic [AW-1:0]            alloc_slot_reg, alloc_slot_next;

    // answer being built
    logic                     res_ok_reg, res_ok_next;
    logic [KW-1:0]            res_kind_reg, res_kind_next;
    logic [AW-1:0]            res_index_reg, res_index_next;
    logic [GW-1:0]            res_gen_reg, res_gen_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_ok_reg, out_ok_next;
    logic [KW-1:0]            out_kind_reg, out_kind_next;
    logic [AW-1:0]            out_index_reg, out_index_next;
    logic [GW-1:0]            out_gen_reg, out_gen_next;

    // free-index ring memory
    logic [AW-1:0]            ring_mem [ghp_pkg::MAX_SLOTS];
    logic [AW-1:0]            ring_q_reg;
    logic                     ring_we;
    logic                     ring_re;
    logic [AW-1:0]            ring_waddr;
    logic [AW-1:0]            ring_wdata;

    ghp_pkg::slot_req_t       slot_req;
    ghp_pkg::slot_rsp_t       slot_rsp;

    logic [CW-1:0]            eff_max;
    logic                     idx_in_range;
    logic                     handle_match;
    logic [CW:0]              ring_sum;
    logic [CW:0]              ring_wpos;
    logic [CW-1:0]            head_inc;
    logic [CW:0]              grown;
    logic [GW-1:0]            gen_bump;
    logic [GW-1:0]            gen_first;
    logic                     out_free;

    ghp_slot_store u_slot_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slot_req),
        .rsp   (slot_rsp)
    );

    // ring memory: one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_q_reg <= ring_mem[ring_head_reg];
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.out_kind       = out_kind_reg;
    assign rsp.out_index      = out_index_reg;
    assign rsp.out_generation = out_gen_reg;

    // datapath helpers
    always_comb
    begin
        eff_max      = ghp_pkg::clamp_max(max_slots_reg);
        idx_in_range = (hidx_reg != '0) && (hidx_reg < HW'(cap_reg));
        handle_match = slot_rsp.used && (slot_rsp.gen == hgen_reg);
        // head + count stays below twice the capacity, so one subtract wraps it
        ring_sum     = (CW+1)'(ring_head_reg) + (CW+1)'(ring_count_reg);
        ring_wpos    = (ring_sum >= (CW+1)'(cap_reg)) ? ring_sum - (CW+1)'(cap_reg)
                                                      : ring_sum;
        head_inc     = CW'(ring_head_reg) + CW'(1);
        grown        = {cap_reg, 1'b0};
        if (grown > (CW+1)'(eff_max))
        begin
            grown = (CW+1)'(eff_max);
        end
        // generation bump skips zero
        gen_bump     = slot_rsp.gen + GW'(1);
        if (gen_bump == '0)
        begin
            gen_bump = GW'(1);
        end
        gen_first    = (slot_rsp.gen == '0) ? GW'(1) : slot_rsp.gen;
        out_free     = !out_valid_reg || rsp.ready;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        hkind_next       = hkind_reg;
        hidx_next        = hidx_reg;
        hgen_next        = hgen_reg;
        pool_kind_next   = pool_kind_reg;
        max_slots_next   = max_slots_reg;
        cap_next         = cap_reg;
        ring_head_next   = ring_head_reg;
        ring_count_next  = ring_count_reg;
        next_unused_next = next_unused_reg;
        scan_idx_next    = scan_idx_reg;
        alloc_slot_next  = alloc_slot_reg;
        res_ok_next      = res_ok_reg;
        res_kind_next    = res_kind_reg;
        res_index_next   = res_index_reg;
        res_gen_next     = res_gen_reg;
        out_valid_next   = out_valid_reg;
        out_ok_next      = out_ok_reg;
        out_kind_next    = out_kind_reg;
        out_index_next   = out_index_reg;
        out_gen_next     = out_gen_reg;
        slot_req         = '0;
        ring_we          = 1'b0;
        ring_re          = 1'b0;
        ring_waddr       = ring_wpos[AW-1:0];
        ring_wdata       = hidx_reg[AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.command;
                    hkind_next = cmd.handle_kind;
                    hidx_next  = cmd.handle_index;
                    hgen_next  = cmd.handle_generation;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_ok_next    = 1'b0;
                res_kind_next  = '0;
                res_index_next = '0;
                res_gen_next   = '0;
                state_next     = S_DONE;
                case (cmd_reg)
                    ghp_pkg::CMD_ALLOC:
                    begin
                        if (pool_kind_reg != '0)
                        begin
                            if (ring_count_reg != '0)
                            begin
                                ring_re    = 1'b1;
                                state_next = S_RING;
                            end
                            else
                            begin
                                scan_idx_next = next_unused_reg;
                                state_next    = S_SCAN_RD;
                            end
                        end
                    end
                    ghp_pkg::CMD_FREE, ghp_pkg::CMD_RESOLVE:
                    begin
                        if (idx_in_range && (hkind_reg == pool_kind_reg))
                        begin
                            slot_req.rd_en = 1'b1;
                            slot_req.addr  = hidx_reg[AW-1:0];
                            state_next     = S_CHECK;
                        end
                    end
                    ghp_pkg::CMD_LOOKUP:
                    begin
                        if (idx_in_range && (pool_kind_reg != '0))
                        begin
                            slot_req.rd_en = 1'b1;
                            slot_req.addr  = hidx_reg[AW-1:0];
                            state_next     = S_CHECK;
                        end
                    end
                    ghp_pkg::CMD_CLEAR:
                    begin
                        slot_req.clr     = 1'b1;
                        ring_head_next   = '0;
                        ring_count_next  = '0;
                        next_unused_next = CW'(1);
                        res_ok_next      = 1'b1;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            // oldest freed index; popped whether or not it checks out
            S_RING:
            begin
                ring_head_next  = (head_inc >= cap_reg) ? '0 : head_inc[AW-1:0];
                ring_count_next = ring_count_reg - CW'(1);
                if ((ring_q_reg != '0) && (CW'(ring_q_reg) < cap_reg))
                begin
                    alloc_slot_next = ring_q_reg;
                    slot_req.rd_en  = 1'b1;
                    slot_req.addr   = ring_q_reg;
                    state_next      = S_ALLOC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN_RD:
            begin
                if (scan_idx_reg < cap_reg)
                begin
                    slot_req.rd_en = 1'b1;
                    slot_req.addr  = scan_idx_reg[AW-1:0];
                    state_next     = S_SCAN_CK;
                end
                else if (cap_reg < eff_max)
                begin
                    // grow: first new slot is the old capacity
                    cap_next         = grown[CW-1:0];
                    next_unused_next = cap_reg + CW'(1);
                    ring_head_next   = '0;
                    alloc_slot_next  = cap_reg[AW-1:0];
                    slot_req.rd_en   = 1'b1;
                    slot_req.addr    = cap_reg[AW-1:0];
                    state_next       = S_ALLOC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN_CK:
            begin
                if (!slot_rsp.used)
                begin
                    next_unused_next = scan_idx_reg + CW'(1);
                    alloc_slot_next  = scan_idx_reg[AW-1:0];
                    state_next       = S_ALLOC;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    state_next    = S_SCAN_RD;
                end
            end

            // read data still holds the chosen slot
            S_ALLOC:
            begin
                slot_req.wr_en = 1'b1;
                slot_req.addr  = alloc_slot_reg;
                slot_req.used  = 1'b1;
                slot_req.gen   = gen_first;
                res_ok_next    = 1'b1;
                res_kind_next  = pool_kind_reg;
                res_index_next = alloc_slot_reg;
                res_gen_next   = gen_first;
                state_next     = S_DONE;
            end

            S_CHECK:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    ghp_pkg::CMD_FREE:
                    begin
                        if (handle_match)
                        begin
                            slot_req.wr_en  = 1'b1;
                            slot_req.addr   = hidx_reg[AW-1:0];
                            slot_req.used   = 1'b0;
                            slot_req.gen    = gen_bump;
                            ring_we         = 1'b1;
                            ring_count_next = ring_count_reg + CW'(1);
                            res_ok_next     = 1'b1;
                        end
                    end
                    ghp_pkg::CMD_RESOLVE:
                    begin
                        if (handle_match)
                        begin
                            res_ok_next    = 1'b1;
                            res_kind_next  = hkind_reg;
                            res_index_next = hidx_reg[AW-1:0];
                            res_gen_next   = hgen_reg;
                        end
                    end
                    ghp_pkg::CMD_LOOKUP:
                    begin
                        if (slot_rsp.used)
                        begin
                            res_ok_next    = 1'b1;
                            res_kind_next  = pool_kind_reg;
                            res_index_next = hidx_reg[AW-1:0];
                            res_gen_next   = slot_rsp.gen;
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_kind_next  = res_kind_reg;
                    out_index_next = res_index_reg;
                    out_gen_next   = res_gen_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes must arrive only while idle; the block does not enforce this
        if (cfg_we)
        begin
            case (cfg_index)
                ghp_pkg::CFG_POOL_KIND:
                begin
                    pool_kind_next = cfg_data[KW-1:0];
                end
                ghp_pkg::CFG_INIT_SLOTS:
                begin
                    slot_req.clr     = 1'b1;
                    ring_head_next   = '0;
                    ring_count_next  = '0;
                    next_unused_next = CW'(1);
                    cap_next         = ghp_pkg::clamp_init(cfg_data[CW-1:0], eff_max);
                end
                ghp_pkg::CFG_MAX_SLOTS:
                begin
                    max_slots_next = cfg_data[CW-1:0];
                end
                default:
                begin
                    max_slots_next = max_slots_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pool_kind_reg   <= '0;
            max_slots_reg   <= CW'(ghp_pkg::MAX_SLOTS);
            cap_reg         <= CW'(2);
            ring_head_reg   <= '0;
            ring_count_reg  <= '0;
            next_unused_reg <= CW'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pool_kind_reg   <= pool_kind_next;
            max_slots_reg   <= max_slots_next;
            cap_reg         <= cap_next;
            ring_head_reg   <= ring_head_next;
            ring_count_reg  <= ring_count_next;
            next_unused_reg <= next_unused_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        hkind_reg      <= hkind_next;
        hidx_reg       <= hidx_next;
        hgen_reg       <= hgen_next;
        scan_idx_reg   <= scan_idx_next;
        alloc_slot_reg <= alloc_slot_next;
        res_ok_reg     <= res_ok_next;
        res_kind_reg   <= res_kind_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        out_ok_reg     <= out_ok_next;
        out_kind_reg   <= out_kind_next;
        out_index_reg  <= out_index_next;
        out_gen_reg    <= out_gen_next;
    end

    // checks
    `GHP_CHECK(a_ring_fits, 1'b1, ring_count_reg < cap_reg, "free ring holds too many entries")
    `GHP_CHECK(a_head_in_cap, 1'b1, CW'(ring_head_reg) < cap_reg, "ring head beyond capacity")
    `GHP_CHECK(a_unused_range, 1'b1, (next_unused_reg != '0) && (next_unused_reg <= cap_reg), "next unused index out of range")
    `GHP_CHECK(a_slot_port, slot_req.wr_en, !slot_req.rd_en && !slot_req.clr, "slot memory read or clear collides with write")
    `GHP_CHECK_NEXT(a_fail_zero, state_reg == S_DONE && out_free && !res_ok_reg, rsp.valid && rsp.out_kind == '0 && rsp.out_index == '0 && rsp.out_generation == '0, "failed answer carries nonzero fields")

endmodule

`default_nettype wire

FILE: sv/ghp_slot_store.sv
// per-slot generation and in-use memory with registered read
// depends on ghp_pkg; entries not written since the last clear read as zero
`timescale 1ns / 1ps
`default_nettype none

module ghp_slot_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ghp_pkg::slot_req_t  req,
    output ghp_pkg::slot_rsp_t       rsp
);

    localparam int DEPTH = ghp_pkg::MAX_SLOTS;

    logic [ghp_pkg::GEN_W:0]   mem [DEPTH];
    logic [DEPTH-1:0]          valid_reg;
    logic [ghp_pkg::GEN_W:0]   rd_data_reg;
    logic                      rd_valid_reg;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= {req.used, req.gen};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    // written-since-clear bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rsp.used = rd_valid_reg & rd_data_reg[ghp_pkg::GEN_W];
    assign rsp.gen  = rd_valid_reg ? rd_data_reg[ghp_pkg::GEN_W-1:0] : '0;

endmodule

`default_nettype wire
